// File: hdl/qtg_pkg.sv
// ----------------------------------------------------------------------------
// qtg_pkg
// Types, codes and the coefficient combination schedule shared by the
// quintic trajectory generator modules.
// ----------------------------------------------------------------------------
`default_nettype none

package qtg_pkg;

  // Input command codes
  localparam logic CMD_PLAN   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_START_POS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_POS   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_ACC = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_END_ACC   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_START_T   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_END_T     = 4'd7;

  localparam logic [23:0] END_TIME_RESET = 24'd655360;

  // Schedule lengths
  localparam int MUL_STEPS = 6;
  localparam int DIV_STEPS = 41;
  localparam int SUM_STEPS = 18;
  localparam int NUM_COEF  = 6;

  // Combination operations
  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;

  // Combination terms
  localparam logic [2:0] TERM_C0 = 3'd0;
  localparam logic [2:0] TERM_DQ = 3'd1;
  localparam logic [2:0] TERM_V0 = 3'd2;
  localparam logic [2:0] TERM_VF = 3'd3;
  localparam logic [2:0] TERM_H0 = 3'd4;
  localparam logic [2:0] TERM_HF = 3'd5;

  typedef struct packed {
    logic [1:0] op;
    logic [2:0] term;
    logic [3:0] k;
    logic       wr;
    logic [2:0] idx;
  } sum_step_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic       accept;
    logic       mul_en;
    logic [2:0] mul_step;
    logic       div_en;
    logic [5:0] div_step;
    logic       sum_en;
    logic [4:0] sum_step;
    logic       tau_mul;
    logic       tau_sel;
    logic       horner_a;
    logic       horner_b;
    logic [2:0] hk;
    logic       load_out;
    logic       out_zero;
    logic       out_err;
  } qtg_cmd_t;

  typedef struct packed {
    logic bad_window;
  } qtg_status_t;

  // Saturating combination of the boundary terms into coefficients 0 to 5.
  function automatic sum_step_t sum_step(input logic [4:0] n);
    sum_step_t s;
    s = '{op: OP_LOAD, term: TERM_C0, k: 4'd1, wr: 1'b0, idx: 3'd0};
    unique case (n)
      5'd0:  s = '{OP_LOAD, TERM_C0, 4'd1,  1'b1, 3'd0};
      5'd1:  s = '{OP_LOAD, TERM_V0, 4'd1,  1'b1, 3'd1};
      5'd2:  s = '{OP_LOAD, TERM_H0, 4'd1,  1'b1, 3'd2};
      5'd3:  s = '{OP_LOAD, TERM_DQ, 4'd10, 1'b0, 3'd3};
      5'd4:  s = '{OP_SUB,  TERM_V0, 4'd6,  1'b0, 3'd3};
      5'd5:  s = '{OP_SUB,  TERM_VF, 4'd4,  1'b0, 3'd3};
      5'd6:  s = '{OP_SUB,  TERM_H0, 4'd3,  1'b0, 3'd3};
      5'd7:  s = '{OP_ADD,  TERM_HF, 4'd1,  1'b1, 3'd3};
      5'd8:  s = '{OP_LOAD, TERM_V0, 4'd8,  1'b0, 3'd4};
      5'd9:  s = '{OP_SUB,  TERM_DQ, 4'd15, 1'b0, 3'd4};
      5'd10: s = '{OP_ADD,  TERM_VF, 4'd7,  1'b0, 3'd4};
      5'd11: s = '{OP_ADD,  TERM_H0, 4'd3,  1'b0, 3'd4};
      5'd12: s = '{OP_SUB,  TERM_HF, 4'd2,  1'b1, 3'd4};
      5'd13: s = '{OP_LOAD, TERM_DQ, 4'd6,  1'b0, 3'd5};
      5'd14: s = '{OP_SUB,  TERM_V0, 4'd3,  1'b0, 3'd5};
      5'd15: s = '{OP_SUB,  TERM_VF, 4'd3,  1'b0, 3'd5};
      5'd16: s = '{OP_SUB,  TERM_H0, 4'd1,  1'b0, 3'd5};
      5'd17: s = '{OP_ADD,  TERM_HF, 4'd1,  1'b1, 3'd5};
      default: s = '{OP_LOAD, TERM_C0, 4'd1, 1'b0, 3'd0};
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/qtg_if.sv
// ----------------------------------------------------------------------------
// qtg interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface qtg_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [23:0] sample_time;
  modport source (output valid, command, sample_time, input ready);
  modport sink (input valid, command, sample_time, output ready);
endinterface

interface qtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] position;
  logic        time_clamped;
  logic        plan_error;
  modport source (output valid, position, time_clamped, plan_error, input ready);
  modport sink (input valid, position, time_clamped, plan_error, output ready);
endinterface

interface qtg_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hdl/qtg_datapath.sv
// ----------------------------------------------------------------------------
// qtg_datapath
// Configuration registers, shared multiplier, divider, coefficient store
// and Horner evaluation for the quintic trajectory generator.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_datapath #(
  parameter int COEFF_FRAC_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire qtg_pkg::qtg_cmd_t   cmd,
  output qtg_pkg::qtg_status_t     status,
  input  wire logic                cfg_we,
  input  wire logic [3:0]          cfg_index,
  input  wire logic [31:0]         cfg_data,
  input  wire logic [23:0]         in_sample_time,
  output logic [31:0]              out_position,
  output logic                     out_time_clamped,
  output logic                     out_plan_error
);

  localparam int LSH = (COEFF_FRAC_BITS >= 32) ? COEFF_FRAC_BITS - 32 : 0;
  localparam int RSH = (COEFF_FRAC_BITS < 32) ? 32 - COEFF_FRAC_BITS : 0;
  localparam int PSH = COEFF_FRAC_BITS - 16;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = ~S64_MAX;
  localparam logic signed [63:0] SHL_HI = S64_MAX >>> LSH;
  localparam logic [32:0] TAU_ONE = 33'h1_0000_0000;

  function automatic logic signed [63:0] clamp69(input logic signed [68:0] x);
    logic signed [63:0] r;
    if (x > 69'sh0_7FFF_FFFF_FFFF_FFFF) r = S64_MAX;
    else if (x < -69'sh0_8000_0000_0000_0000) r = S64_MIN;
    else r = x[63:0];
    return r;
  endfunction

  function automatic logic signed [63:0] clamp65(input logic signed [64:0] x);
    logic signed [63:0] r;
    if (x[64] != x[63]) r = x[64] ? S64_MIN : S64_MAX;
    else r = x[63:0];
    return r;
  endfunction

  function automatic logic signed [63:0] to_coeff(input logic signed [63:0] x);
    logic signed [63:0] r;
    if (x > SHL_HI) r = S64_MAX;
    else if (x < ~SHL_HI) r = S64_MIN;
    else r = (x <<< LSH) >>> RSH;
    return r;
  endfunction

  // Configuration registers
  logic signed [31:0] q0_r, qf_r, v0r_r, vfr_r, a0_r, af_r;
  logic [23:0]        ts0_r, tsf_r;

  // Working registers
  logic [23:0]        d_r, ts_r;
  logic               below_r, atend_r, clamp_r;
  logic signed [39:0] p_r;
  logic signed [63:0] v0_r, vf_r, h0_r, hf_r;
  logic [24:0]        rem_r;
  logic [40:0]        q_r;
  logic [31:0]        inv_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] coef_r [qtg_pkg::NUM_COEF];
  logic [47:0]        tprod_r;
  logic [32:0]        tau_r;
  logic signed [63:0] mh_r;
  logic [32:0]        ml_r;
  logic [31:0]        pos_r;
  logic               tcl_r, perr_r;

  assign status.bad_window = (tsf_r <= ts0_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q0_r  <= '0;
      qf_r  <= '0;
      v0r_r <= '0;
      vfr_r <= '0;
      a0_r  <= '0;
      af_r  <= '0;
      ts0_r <= '0;
      tsf_r <= qtg_pkg::END_TIME_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        qtg_pkg::REG_START_POS: q0_r  <= cfg_data;
        qtg_pkg::REG_END_POS:   qf_r  <= cfg_data;
        qtg_pkg::REG_START_VEL: v0r_r <= cfg_data;
        qtg_pkg::REG_END_VEL:   vfr_r <= cfg_data;
        qtg_pkg::REG_START_ACC: a0_r  <= cfg_data;
        qtg_pkg::REG_END_ACC:   af_r  <= cfg_data;
        qtg_pkg::REG_START_T:   ts0_r <= cfg_data[23:0];
        qtg_pkg::REG_END_T:     tsf_r <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // Shared multiplier: boundary products during a plan, tau during a sample.
  logic signed [39:0] ma;
  logic signed [24:0] mb;
  logic signed [64:0] pm;

  always_comb begin
    ma = {{8{a0_r[31]}}, a0_r};
    mb = $signed({1'b0, d_r});
    if (cmd.tau_mul) begin
      ma = $signed({8'h00, inv_r});
      mb = $signed({1'b0, ts_r - ts0_r});
    end else begin
      case (cmd.mul_step)
        3'd0: ma = {{8{v0r_r[31]}}, v0r_r};
        3'd1: ma = {{8{vfr_r[31]}}, vfr_r};
        3'd2: ma = {{8{a0_r[31]}}, a0_r};
        3'd4: ma = {{8{af_r[31]}}, af_r};
        default: ma = p_r;
      endcase
    end
    pm = ma * mb;
  end

  // Restoring divider for 2^40 / d, one quotient bit per step.
  logic [25:0] rem_sh;
  logic        q_bit;
  logic [24:0] rem_nxt;
  logic [40:0] q_nxt;

  always_comb begin
    rem_sh = {rem_r, (cmd.div_step == 6'd0)};
    q_bit  = (rem_sh >= {2'b00, d_r});
    rem_nxt = q_bit ? 25'(rem_sh - {2'b00, d_r}) : rem_sh[24:0];
    q_nxt  = {q_r[39:0], q_bit};
  end

  // Coefficient combination step
  qtg_pkg::sum_step_t st;
  logic signed [63:0] term, sc, acc_nxt;
  logic signed [68:0] sprod;

  always_comb begin
    st = qtg_pkg::sum_step(cmd.sum_step);
    case (st.term)
      qtg_pkg::TERM_DQ: term = 64'($signed({qf_r[31], qf_r} - {q0_r[31], q0_r})) <<< 16;
      qtg_pkg::TERM_V0: term = v0_r;
      qtg_pkg::TERM_VF: term = vf_r;
      qtg_pkg::TERM_H0: term = h0_r;
      qtg_pkg::TERM_HF: term = hf_r;
      default:          term = 64'(q0_r) <<< 16;
    endcase
    sprod = term * $signed({1'b0, st.k});
    sc = clamp69(sprod);
    case (st.op)
      qtg_pkg::OP_ADD: acc_nxt = clamp65(65'(acc_r) + 65'(sc));
      qtg_pkg::OP_SUB: acc_nxt = clamp65(65'(acc_r) - 65'(sc));
      default:         acc_nxt = sc;
    endcase
  end

  // Horner step pieces
  logic signed [65:0] mh;
  logic [64:0]        ml;
  logic signed [63:0] msum;
  logic signed [63:0] hsum;
  logic signed [63:0] pshift;

  always_comb begin
    mh = $signed(acc_r[63:32]) * $signed({1'b0, tau_r});
    ml = {32'd0, acc_r[31:0]} * {32'd0, tau_r};
    msum = mh_r + $signed({31'd0, ml_r});
    hsum = clamp65(65'(coef_r[cmd.hk]) + 65'(msum));
    pshift = acc_r >>> PSH;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      d_r     <= tsf_r - ts0_r;
      ts_r    <= in_sample_time;
      below_r <= (in_sample_time < ts0_r);
      atend_r <= (in_sample_time >= tsf_r);
      clamp_r <= (in_sample_time < ts0_r) || (in_sample_time > tsf_r);
      rem_r   <= '0;
      q_r     <= '0;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_step)
        3'd0: v0_r <= pm[63:0];
        3'd1: vf_r <= pm[63:0];
        3'd3: h0_r <= pm[64:1];
        3'd5: hf_r <= pm[64:1];
        default: p_r <= pm[55:16];
      endcase
    end
    if (cmd.div_en) begin
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
      if (cmd.div_step == 6'(qtg_pkg::DIV_STEPS - 1))
        inv_r <= (|q_nxt[40:32]) ? 32'hFFFF_FFFF : q_nxt[31:0];
    end
    if (cmd.sum_en) begin
      acc_r <= acc_nxt;
      if (st.wr) coef_r[st.idx] <= to_coeff(acc_nxt);
    end
    if (cmd.tau_mul) tprod_r <= pm[55:8];
    if (cmd.tau_sel) begin
      if (below_r) tau_r <= '0;
      else if (atend_r || (tprod_r > 48'(TAU_ONE))) tau_r <= TAU_ONE;
      else tau_r <= tprod_r[32:0];
      acc_r <= coef_r[3'd5];
    end
    if (cmd.horner_a) begin
      mh_r <= mh[63:0];
      ml_r <= ml[64:32];
    end
    if (cmd.horner_b) acc_r <= hsum;
    if (cmd.load_out) begin
      if (cmd.out_zero) pos_r <= '0;
      else if (pshift > 64'sh0000_0000_7FFF_FFFF) pos_r <= 32'h7FFF_FFFF;
      else if (pshift < -64'sh0000_0000_8000_0000) pos_r <= 32'h8000_0000;
      else pos_r <= pshift[31:0];
      tcl_r  <= !cmd.out_zero && clamp_r;
      perr_r <= cmd.out_err;
    end
  end

  assign out_position     = pos_r;
  assign out_time_clamped = tcl_r;
  assign out_plan_error   = perr_r;

endmodule

`default_nettype wire

// File: hdl/qtg_ctrl.sv
// ----------------------------------------------------------------------------
// qtg_ctrl
// Sequencer for plan and sample commands and the result handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module qtg_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_command,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire qtg_pkg::qtg_status_t status,
  output qtg_pkg::qtg_cmd_t         cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PMUL = 4'd1;
  localparam logic [3:0] S_PDIV = 4'd2;
  localparam logic [3:0] S_PSUM = 4'd3;
  localparam logic [3:0] S_TMUL = 4'd4;
  localparam logic [3:0] S_TSEL = 4'd5;
  localparam logic [3:0] S_HA   = 4'd6;
  localparam logic [3:0] S_HB   = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic       pv_r, pv_nxt;
  logic       zero_r, zero_nxt;
  logic       err_r, err_nxt;
  logic       ov_r, ov_nxt;
  logic       acc_in;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;
  assign acc_in    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pv_nxt    = pv_r;
    zero_nxt  = zero_r;
    err_nxt   = err_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.mul_step = cnt_r[2:0];
    cmd.div_step = cnt_r;
    cmd.sum_step = cnt_r[4:0];
    cmd.hk       = cnt_r[2:0];
    cmd.out_zero = zero_r;
    cmd.out_err  = err_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = acc_in;
        cnt_nxt = '0;
        if (acc_in) begin
          zero_nxt = 1'b1;
          err_nxt  = 1'b0;
          if (in_command == qtg_pkg::CMD_PLAN) begin
            if (status.bad_window) begin
              pv_nxt    = 1'b0;
              err_nxt   = 1'b1;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_PMUL;
            end
          end else if (!pv_r) begin
            err_nxt   = 1'b1;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_TMUL;
          end
        end
      end
      S_PMUL: begin
        cmd.mul_en = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(qtg_pkg::MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PDIV;
        end
      end
      S_PDIV: begin
        cmd.div_en = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(qtg_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_PSUM;
        end
      end
      S_PSUM: begin
        cmd.sum_en = 1'b1;
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(qtg_pkg::SUM_STEPS - 1)) begin
          pv_nxt    = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_TMUL: begin
        cmd.tau_mul = 1'b1;
        state_nxt = S_TSEL;
      end
      S_TSEL: begin
        cmd.tau_sel = 1'b1;
        cnt_nxt   = 6'd4;
        state_nxt = S_HA;
      end
      S_HA: begin
        cmd.horner_a = 1'b1;
        state_nxt = S_HB;
      end
      S_HB: begin
        cmd.horner_b = 1'b1;
        if (cnt_r == 6'd0) begin
          zero_nxt  = 1'b0;
          state_nxt = S_FIN;
        end else begin
          cnt_nxt   = cnt_r - 6'd1;
          state_nxt = S_HA;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          cmd.load_out = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      zero_r  <= 1'b1;
      err_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      zero_r  <= zero_nxt;
      err_r   <= err_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.mul_en, cmd.div_en, cmd.sum_en, cmd.tau_mul, cmd.tau_sel,
              cmd.horner_a, cmd.horner_b, cmd.load_out}))
    else $error("more than one datapath unit commanded");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("result loaded but not presented");

  a_bad_plan: assert property (@(posedge clk) disable iff (!rst_n)
    (acc_in && in_command == qtg_pkg::CMD_PLAN && status.bad_window) |=> !pv_r)
    else $error("plan still valid after a bad window");

  a_plan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PSUM && cnt_r == 6'(qtg_pkg::SUM_STEPS - 1)) |=> pv_r)
    else $error("plan finished without marking it valid");

endmodule

`default_nettype wire

// File: hdl/quintic_trajectory_generator_top.sv
// ----------------------------------------------------------------------------
// quintic_trajectory_generator_top
// One-axis quintic point-to-point trajectory: plan and sample commands.
// ----------------------------------------------------------------------------
// A plan item runs from acceptance to a result through six steps of the
// shared multiplier for the boundary products, 41 steps of the bit-serial
// divider that forms the inverse duration, 18 saturating combination steps
// and the load of the result register. A sample item takes one multiply
// for tau, a clamp of tau, five Horner steps, each a multiply phase and an
// add phase through the coefficient multipliers, and the result load.
// Rejected items (bad window, sample before plan) go straight to the result
// load. One item is in work at a time; the result register lets the next
// item start while the previous result waits to be taken.
`default_nettype none

module quintic_trajectory_generator_top #(
  parameter int COEFF_FRAC_BITS = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  qtg_in_if.sink     in_ch,
  qtg_out_if.source  out_ch,
  qtg_cfg_if.sink    cfg_ch
);

  qtg_pkg::qtg_cmd_t    cmd;
  qtg_pkg::qtg_status_t status;

  assign cfg_ch.ready = 1'b1;

  qtg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_command (in_ch.command),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .status     (status),
    .cmd        (cmd)
  );

  qtg_datapath #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_ch.valid),
    .cfg_index        (cfg_ch.index),
    .cfg_data         (cfg_ch.data),
    .in_sample_time   (in_ch.sample_time),
    .out_position     (out_ch.position),
    .out_time_clamped (out_ch.time_clamped),
    .out_plan_error   (out_ch.plan_error)
  );

endmodule

`default_nettype wire
